// File: src/meshlet_triangle_packer_macros.svh
// -----------------------------------------------------------------------------
// meshlet_triangle_packer_macros: assertion helpers
// Clocked on clk_i and held off while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef MESHLET_TRIANGLE_PACKER_MACROS_SVH
`define MESHLET_TRIANGLE_PACKER_MACROS_SVH

// Check a condition at every edge
`define MTP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition implies another in the same cycle
`define MTP_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// File: src/mtp_pkg.sv
// -----------------------------------------------------------------------------
// mtp_pkg: shared types and constants of the meshlet triangle packer
// Field widths, result kinds, register indexes and the lookup status bundle.
// -----------------------------------------------------------------------------
package mtp_pkg;

  // Payload widths
  localparam int unsigned CORNER_W    = 32;
  localparam int unsigned NUM_CORNERS = 3;
  localparam int unsigned TW_W        = 24;
  localparam int unsigned OFF_W       = 32;
  localparam int unsigned VC_W        = 7;
  localparam int unsigned TC_W        = 8;
  localparam int unsigned SLOT_W      = 8;
  localparam int unsigned CALC_W      = 10;

  // Stream and config port widths
  localparam int unsigned IN_DATA_W    = ((NUM_CORNERS * CORNER_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = CORNER_W + TW_W + 2 * OFF_W + VC_W + TC_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam int unsigned CFG_ADDR_W   = 1;

  // Parameter defaults
  localparam int unsigned MAX_VERTICES_DEF  = 64;
  localparam int unsigned MAX_TRIANGLES_DEF = 128;

  // Limit register resets and clamp floors
  localparam logic [VC_W-1:0] VLIM_RESET = 7'd64;
  localparam logic [TC_W-1:0] TLIM_RESET = 8'd128;
  localparam int unsigned     VLIM_MIN   = 3;
  localparam int unsigned     TLIM_MIN   = 1;

  typedef enum logic [1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_MESHLET  = 2'd2
  } kind_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_VERTEX_LIMIT   = 1'b0,
    REG_TRIANGLE_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CLOSE,
    ST_VERT,
    ST_TRI,
    ST_END
  } state_e;

  // Per-corner match status from the cell row
  typedef struct packed {
    logic [NUM_CORNERS-1:0]             hit;
    logic [NUM_CORNERS-1:0][SLOT_W-1:0] pos;
  } lookup_t;

  function automatic logic [OFF_W-1:0] sat_inc(input logic [OFF_W-1:0] v);
    return (v == '1) ? v : v + OFF_W'(1);
  endfunction

endpackage

// File: src/meshlet_triangle_packer.sv
// -----------------------------------------------------------------------------
// meshlet_triangle_packer: greedy meshlet builder over a row of slot cells
// Order: each accepted triangle passes LOOK, an optional CLOSE, one VERT step per corner,
//   TRI and, at end of mesh, END; 1 to 6 results.
// A new triangle is taken only in IDLE, once the last one is done; output stalls hold
//   the steps that emit, and one slot-row lookup per corner sets the pace.
// Reset: limits 64/128, counters and totals zero; slot cells not cleared.
// -----------------------------------------------------------------------------
`include "meshlet_triangle_packer_macros.svh"

module meshlet_triangle_packer #(
  parameter int unsigned MAX_VERTICES  = mtp_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MAX_TRIANGLES = mtp_pkg::MAX_TRIANGLES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [mtp_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [mtp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Triangle input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: corner_a[31:0], corner_b[63:32], corner_c[95:64]
  input  logic [mtp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tlast: end_of_mesh
  input  logic                             s_axis_tlast,
  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: vertex_global[31:0], triangle_word[55:32], meshlet_vertex_offset[87:56],
  //        meshlet_triangle_offset[119:88], meshlet_vertex_count[126:120],
  //        meshlet_triangle_count[134:127], zero pad[135]
  output logic [mtp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // tuser: kind[1:0]
  output logic [1:0]                       m_axis_tuser,
  // tlast: last_of_run
  output logic                             m_axis_tlast
);
  import mtp_pkg::*;

  localparam int unsigned VCNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned TCNT_W = $clog2(MAX_TRIANGLES + 1);

  // Config and control state
  logic [VC_W-1:0]   vlim_q;
  logic [TC_W-1:0]   tlim_q;
  state_e            state_q, state_d;
  logic [1:0]        cidx_q, cidx_d;
  logic [VCNT_W-1:0] slots_used_q, slots_used_d;
  logic [TCNT_W-1:0] open_tri_q, open_tri_d;
  logic [OFF_W-1:0]  total_v_q, total_v_d;
  logic [OFF_W-1:0]  total_t_q, total_t_d;
  logic [OFF_W-1:0]  off_v_q, off_v_d;
  logic [OFF_W-1:0]  off_t_q, off_t_d;

  // Item payload
  logic [NUM_CORNERS-1:0][CORNER_W-1:0] corner_q, corner_d;
  logic                                 eom_q, eom_d;
  logic [NUM_CORNERS-1:0][SLOT_W-1:0]   slot_q, slot_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q, out_kind_d;
  logic [CORNER_W-1:0] out_vg_q, out_vg_d;
  logic [TW_W-1:0]   out_tw_q, out_tw_d;
  logic [OFF_W-1:0]  out_vo_q, out_vo_d;
  logic [OFF_W-1:0]  out_to_q, out_to_d;
  logic [VC_W-1:0]   out_vc_q, out_vc_d;
  logic [TC_W-1:0]   out_tc_q, out_tc_d;
  logic              out_last_q, out_last_d;

  // Combinational helpers
  lookup_t           lookup;
  logic              s_accept;
  logic              can_emit;
  logic              emit_req;
  logic              emit;
  logic              step_done;
  logic              append;
  kind_e             emit_kind;
  logic              emit_last;
  logic              sel_hit;
  logic [SLOT_W-1:0] sel_pos;
  logic [CORNER_W-1:0] sel_corner;
  logic [CALC_W-1:0] slots_ext;
  logic [CALC_W-1:0] tri_ext;
  logic [CALC_W-1:0] hit_slot_ext;
  logic [CALC_W-1:0] fresh;
  logic [CALC_W-1:0] vlim_eff;
  logic [CALC_W-1:0] tlim_eff;
  logic              close_need;

  assign s_accept   = s_axis_tvalid && s_axis_tready;
  assign can_emit   = !out_valid_q || m_axis_tready;
  assign emit       = emit_req && can_emit;
  assign sel_hit    = lookup.hit[cidx_q];
  assign sel_pos    = lookup.pos[cidx_q];
  assign sel_corner = corner_q[cidx_q];
  assign slots_ext  = CALC_W'(slots_used_q);
  assign tri_ext    = CALC_W'(open_tri_q);
  // Slot of a matching cell: newest vertex sits in cell 0
  assign hit_slot_ext = slots_ext - CALC_W'(1) - CALC_W'(sel_pos);

  // Slot cell row
  mtp_chain #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_chain (
    .clk_i        (clk_i),
    .shift_i      (append),
    .shift_data_i (sel_corner),
    .count_i      (slots_used_q),
    .corners_i    (corner_q),
    .lookup_o     (lookup)
  );

  // Clamp the limits and test whether the triangle fits the open meshlet
  always_comb begin
    vlim_eff = CALC_W'(vlim_q);
    if (vlim_eff < CALC_W'(VLIM_MIN)) begin
      vlim_eff = CALC_W'(VLIM_MIN);
    end else if (vlim_eff > CALC_W'(MAX_VERTICES)) begin
      vlim_eff = CALC_W'(MAX_VERTICES);
    end
    tlim_eff = CALC_W'(tlim_q);
    if (tlim_eff < CALC_W'(TLIM_MIN)) begin
      tlim_eff = CALC_W'(TLIM_MIN);
    end else if (tlim_eff > CALC_W'(MAX_TRIANGLES)) begin
      tlim_eff = CALC_W'(MAX_TRIANGLES);
    end
    fresh = '0;
    for (int c = 0; c < NUM_CORNERS; c++) begin
      fresh = fresh + CALC_W'(!lookup.hit[c]);
    end
    close_need = (slots_ext + fresh > vlim_eff) || (tri_ext + CALC_W'(1) > tlim_eff);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cidx_d  = cidx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cidx_d  = 2'd0;
        state_d = close_need ? ST_CLOSE : ST_VERT;
      end
      ST_CLOSE: begin
        if (step_done) begin
          state_d = ST_VERT;
        end
      end
      ST_VERT: begin
        if (step_done) begin
          if (cidx_q == 2'(NUM_CORNERS - 1)) begin
            state_d = ST_TRI;
          end else begin
            cidx_d = cidx_q + 2'd1;
          end
        end
      end
      ST_TRI: begin
        if (step_done) begin
          state_d = eom_q ? ST_END : ST_IDLE;
        end
      end
      ST_END: begin
        if (step_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State outputs: handshake, result request, append
  always_comb begin
    s_axis_tready = 1'b0;
    emit_req      = 1'b0;
    emit_kind     = KIND_VERTEX;
    emit_last     = 1'b0;
    step_done     = 1'b0;
    append        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_LOOK: begin
        step_done = 1'b1;
      end
      ST_CLOSE: begin
        // An empty meshlet closes without a record
        if (open_tri_q != '0) begin
          emit_req  = 1'b1;
          emit_kind = KIND_MESHLET;
          step_done = can_emit;
        end else begin
          step_done = 1'b1;
        end
      end
      ST_VERT: begin
        if (sel_hit) begin
          step_done = 1'b1;
        end else begin
          emit_req  = 1'b1;
          emit_kind = KIND_VERTEX;
          step_done = can_emit;
          append    = can_emit;
        end
      end
      ST_TRI: begin
        emit_req  = 1'b1;
        emit_kind = KIND_TRIANGLE;
        emit_last = !eom_q;
        step_done = can_emit;
      end
      ST_END: begin
        emit_req  = 1'b1;
        emit_kind = KIND_MESHLET;
        emit_last = 1'b1;
        step_done = can_emit;
      end
      default: begin
        step_done = 1'b0;
      end
    endcase
  end

  // Meshlet counters, running totals and item payload
  always_comb begin
    slots_used_d = slots_used_q;
    open_tri_d   = open_tri_q;
    total_v_d    = total_v_q;
    total_t_d    = total_t_q;
    off_v_d      = off_v_q;
    off_t_d      = off_t_q;
    corner_d     = corner_q;
    eom_d        = eom_q;
    slot_d       = slot_q;

    if (s_accept) begin
      corner_d[0] = s_axis_tdata[CORNER_W-1:0];
      corner_d[1] = s_axis_tdata[2*CORNER_W-1:CORNER_W];
      corner_d[2] = s_axis_tdata[3*CORNER_W-1:2*CORNER_W];
      eom_d       = s_axis_tlast;
    end

    // Close the open meshlet before the triangle goes in
    if (state_q == ST_CLOSE && step_done) begin
      off_v_d      = total_v_q;
      off_t_d      = total_t_q;
      slots_used_d = '0;
      open_tri_d   = '0;
    end

    // Resolve one corner: reuse a slot or append a vertex
    if (state_q == ST_VERT && step_done) begin
      if (sel_hit) begin
        slot_d[cidx_q] = hit_slot_ext[SLOT_W-1:0];
      end else begin
        slot_d[cidx_q] = slots_ext[SLOT_W-1:0];
        slots_used_d   = slots_used_q + VCNT_W'(1);
        total_v_d      = sat_inc(total_v_q);
      end
    end

    if (state_q == ST_TRI && step_done) begin
      total_t_d  = sat_inc(total_t_q);
      open_tri_d = open_tri_q + TCNT_W'(1);
    end

    // End of mesh: the next triangle starts from zero
    if (state_q == ST_END && step_done) begin
      slots_used_d = '0;
      open_tri_d   = '0;
      total_v_d    = '0;
      total_t_d    = '0;
      off_v_d      = '0;
      off_t_d      = '0;
    end
  end

  // Load the output register on a result, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_vg_d    = out_vg_q;
    out_tw_d    = out_tw_q;
    out_vo_d    = out_vo_q;
    out_to_d    = out_to_q;
    out_vc_d    = out_vc_q;
    out_tc_d    = out_tc_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = emit_kind;
      out_last_d  = emit_last;
      out_vg_d    = '0;
      out_tw_d    = '0;
      out_vo_d    = '0;
      out_to_d    = '0;
      out_vc_d    = '0;
      out_tc_d    = '0;
      case (emit_kind)
        KIND_VERTEX: begin
          out_vg_d = sel_corner;
        end
        KIND_TRIANGLE: begin
          out_tw_d = {slot_q[2], slot_q[1], slot_q[0]};
        end
        KIND_MESHLET: begin
          out_vo_d = off_v_q;
          out_to_d = off_t_q;
          out_vc_d = slots_ext[VC_W-1:0];
          out_tc_d = tri_ext[TC_W-1:0];
        end
        default: begin
          out_vg_d = '0;
        end
      endcase
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlim_q       <= VLIM_RESET;
      tlim_q       <= TLIM_RESET;
      state_q      <= ST_IDLE;
      cidx_q       <= 2'd0;
      slots_used_q <= '0;
      open_tri_q   <= '0;
      total_v_q    <= '0;
      total_t_q    <= '0;
      off_v_q      <= '0;
      off_t_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_addr_i))
          REG_VERTEX_LIMIT: begin
            vlim_q <= cfg_data_i[VC_W-1:0];
          end
          REG_TRIANGLE_LIMIT: begin
            tlim_q <= cfg_data_i[TC_W-1:0];
          end
          default: begin
            vlim_q <= vlim_q;
          end
        endcase
      end
      state_q      <= state_d;
      cidx_q       <= cidx_d;
      slots_used_q <= slots_used_d;
      open_tri_q   <= open_tri_d;
      total_v_q    <= total_v_d;
      total_t_q    <= total_t_d;
      off_v_q      <= off_v_d;
      off_t_q      <= off_t_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    corner_q   <= corner_d;
    eom_q      <= eom_d;
    slot_q     <= slot_d;
    out_kind_q <= out_kind_d;
    out_vg_q   <= out_vg_d;
    out_tw_q   <= out_tw_d;
    out_vo_q   <= out_vo_d;
    out_to_q   <= out_to_d;
    out_vc_q   <= out_vc_d;
    out_tc_q   <= out_tc_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, out_tc_q, out_vc_q,
                          out_to_q, out_vo_q, out_tw_q, out_vg_q};

  // Slot count never runs past the cell row
  `MTP_ASSERT(a_slots_bound, slots_used_q <= VCNT_W'(MAX_VERTICES), "slot count past cell row")
  // Open triangle count never runs past the largest limit
  `MTP_ASSERT(a_tri_bound, open_tri_q <= TCNT_W'(MAX_TRIANGLES), "triangle count past limit")
  // A matching cell always lies inside the used slots
  `MTP_ASSERT_IMPL(a_hit_in_use, state_q == ST_VERT && sel_hit, CALC_W'(sel_pos) < slots_ext, "match outside used slots")
  // The last beat of an item is a triangle or a closing record
  `MTP_ASSERT_IMPL(a_last_kind, m_axis_tvalid && m_axis_tlast, m_axis_tuser == KIND_TRIANGLE || m_axis_tuser == KIND_MESHLET, "last beat of wrong kind")

endmodule

// File: src/mtp_cell.sv
// -----------------------------------------------------------------------------
// mtp_cell: one slot of the open meshlet's vertex table
// Holds one global index, takes its neighbor's index on a shift and
// compares itself against the three corners of the current triangle.
// -----------------------------------------------------------------------------
module mtp_cell (
  input  logic                                                 clk_i,
  input  logic                                                 shift_i,
  input  logic                                                 valid_i,
  input  logic [mtp_pkg::CORNER_W-1:0]                         entry_i,
  input  logic [mtp_pkg::NUM_CORNERS-1:0][mtp_pkg::CORNER_W-1:0] corners_i,
  output logic [mtp_pkg::CORNER_W-1:0]                         entry_o,
  output logic [mtp_pkg::NUM_CORNERS-1:0]                      hit_o
);
  import mtp_pkg::*;

  logic [CORNER_W-1:0] entry_q;
  logic [CORNER_W-1:0] entry_d;

  // Take the neighbor's entry on a shift, else hold
  assign entry_d = shift_i ? entry_i : entry_q;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // Match against each corner, only while this slot is in use
  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      hit_o[c] = valid_i && (entry_q == corners_i[c]);
    end
  end

  assign entry_o = entry_q;

endmodule

// File: src/mtp_chain.sv
// -----------------------------------------------------------------------------
// mtp_chain: row of slot cells with per-corner match encoders
// New vertices enter at cell 0 and push older ones one cell along, so the
// entry in cell p holds slot (count - 1 - p).
// -----------------------------------------------------------------------------
module mtp_chain #(
  parameter  int unsigned MAX_VERTICES = mtp_pkg::MAX_VERTICES_DEF,
  localparam int unsigned VcntW        = $clog2(MAX_VERTICES + 1)
) (
  input  logic                                                 clk_i,
  input  logic                                                 shift_i,
  input  logic [mtp_pkg::CORNER_W-1:0]                         shift_data_i,
  input  logic [VcntW-1:0]                                     count_i,
  input  logic [mtp_pkg::NUM_CORNERS-1:0][mtp_pkg::CORNER_W-1:0] corners_i,
  output mtp_pkg::lookup_t                                     lookup_o
);
  import mtp_pkg::*;

  logic [MAX_VERTICES-1:0][CORNER_W-1:0]    entry;
  logic [MAX_VERTICES-1:0][NUM_CORNERS-1:0] hit;
  logic [MAX_VERTICES-1:0]                  cell_valid;

  // Build the row; each cell feeds the next one
  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    logic [CORNER_W-1:0] entry_in;

    if (i == 0) begin : g_head
      assign entry_in = shift_data_i;
    end else begin : g_body
      assign entry_in = entry[i-1];
    end

    assign cell_valid[i] = (VcntW'(i) < count_i);

    mtp_cell u_cell (
      .clk_i     (clk_i),
      .shift_i   (shift_i),
      .valid_i   (cell_valid[i]),
      .entry_i   (entry_in),
      .corners_i (corners_i),
      .entry_o   (entry[i]),
      .hit_o     (hit[i])
    );
  end

  // Encode the matching cell per corner; entries are distinct, so OR the indexes
  always_comb begin
    lookup_o = '0;
    for (int c = 0; c < NUM_CORNERS; c++) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        if (hit[i][c]) begin
          lookup_o.hit[c] = 1'b1;
          lookup_o.pos[c] = lookup_o.pos[c] | SLOT_W'(i);
        end
      end
    end
  end

endmodule
